// File: src/iqd_pkg.sv
package iqd_pkg;

    // Fixed field and state widths
    localparam int CNT_W       = 16;
    localparam int SUM_W       = 32;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 10;
    localparam int CFG_DATA_W  = 2;
    localparam int CFG_INDEX_W = 1;

    // Gain ceiling: 50.0 in Q6.10
    localparam logic [GAIN_W-1:0] GAIN_MAX = 16'd51200;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEMOD_MODE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_AGC_ENABLE = 1'b1;

    typedef enum logic [1:0] {
        MODE_AM    = 2'd0,
        MODE_UPPER = 2'd1,
        MODE_LOWER = 2'd2,
        MODE_CW    = 2'd3
    } demod_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROOT,
        ST_AUDIO,
        ST_RESULT,
        ST_AVG,
        ST_GAIN
    } iqd_state_t;

endpackage

// File: src/iqd_sqrt_serial.sv
module iqd_sqrt_serial #(
    parameter int RT_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2*RT_W-1:0] radicand,
    output logic              done,
    output logic [RT_W-1:0]   root
);

    localparam int REM_W  = RT_W + 3;
    localparam int STEP_W = $clog2(RT_W + 1);

    logic [2*RT_W-1:0] rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [RT_W-1:0]   root_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;
    logic              fits;

    // One root bit per cycle: bring down two radicand bits, try 4*root+1
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[2*RT_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        fits      = (rem_shift >= trial);
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(RT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[RT_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: src/iqd_div_serial.sv
module iqd_div_serial #(
    parameter int DIVD_W = 32,
    parameter int DIVR_W = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] quo_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] div_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVR_W:0]   trial;
    logic [DIVR_W:0]   diff;
    logic              fits;

    // Restoring step: one quotient bit per cycle, MSB first
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVD_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: src/iq_demodulator_dc_agc.sv
// AM envelope demodulator with block-wise DC removal and AGC gain estimate.
// Input channel: i_sample, q_sample (offset binary), block_last; a transfer
// happens on a clock edge with in_valid high and in_stall low.
// Output channel: audio_sample, agc_gain (Q6.10), narrow_filter_request,
// block_end; one result per input, transferred with out_valid high and
// out_stall low. An output register holds the result, so the next input is
// taken while a result still waits for the receiver.
// Items are processed one at a time. An AM item runs the shift-add
// square/slope multiply and then the bit-serial square root; USB/LSB/CW
// items skip both. A block's last item adds the average division and,
// with AGC on and a nonzero peak, the gain division, both on one shared
// bit-serial divider.
// A stalled receiver holds the result; the core waits on a finished result
// until the output register frees up, then continues.
// Reset clears the configuration, block counters, average, slope, peak and
// gain, and empties the output register.
module iq_demodulator_dc_agc
    import iqd_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int INTERP_LENGTH = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // Input channel
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [SAMPLE_WIDTH-1:0] q_sample,
    input  logic                    block_last,
    // Output channel
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SAMPLE_WIDTH-1:0] audio_sample,
    output logic [GAIN_W-1:0]       agc_gain,
    output logic                    narrow_filter_request,
    output logic                    block_end
);

    // INTERP_LENGTH must be a power of two, not checked here; the DC term divides by a shift
    localparam int SW        = SAMPLE_WIDTH;
    localparam int LEN_LOG2  = $clog2(INTERP_LENGTH);
    localparam int MUL_STEPS = (SW > CNT_W) ? SW : CNT_W;
    localparam int STEP_W    = $clog2(MUL_STEPS + 1);
    localparam int AVG_W     = (SW + 1 > SUM_W - CNT_W + 1) ? SW + 1 : SUM_W - CNT_W + 1;
    localparam int SLP_W     = AVG_W + 1;
    localparam int PROD_W    = SLP_W + CNT_W;
    localparam int NUM_W     = ((SW + LEN_LOG2 + 3 > PROD_W) ? SW + LEN_LOG2 + 3 : PROD_W) + 2;
    localparam int DIVD_W    = (SUM_W > SW + GAIN_FRAC) ? SUM_W : SW + GAIN_FRAC;
    localparam int DIVR_W    = (SW > CNT_W) ? SW : CNT_W;

    localparam logic [SW-1:0]     OFS      = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SW-1:0]     FULL_MAX = '1;
    localparam logic [DIVD_W-1:0] GAIN_NUM = DIVD_W'(1) << (SW - 1 + GAIN_FRAC);

    // State and configuration
    iqd_state_t        state_reg, state_next;
    demod_mode_t       mode_reg;
    logic              agc_en_reg;

    // Block state
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [AVG_W-1:0]  prev_reg;
    logic [SLP_W-1:0]  slope_reg;
    logic [SW-1:0]     peak_reg;
    logic [GAIN_W-1:0] gain_reg;

    // Shift-add multipliers
    logic [2*SW-1:0]   mcand_i_reg, mcand_q_reg;
    logic [SW-1:0]     mpl_i_reg, mpl_q_reg;
    logic [2*SW-1:0]   sq_i_reg, sq_q_reg;
    logic [PROD_W-1:0] prod_mcand_reg;
    logic [CNT_W-1:0]  prod_mpl_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [STEP_W-1:0] step_reg;

    // Item datapath
    logic [NUM_W-1:0]  x_reg;
    logic [SW-1:0]     audio_calc_reg;
    logic              last_reg;

    // Output register
    logic              out_valid_reg;
    logic [SW-1:0]     audio_out_reg;
    logic [GAIN_W-1:0] gain_out_reg;
    logic              narrow_reg;
    logic              block_end_reg;

    // Control strobes
    logic              in_xfer;
    logic              out_free;
    logic              in_stall_int;
    logic              mul_step;
    logic              root_start;
    logic              out_load;
    logic              div_start;
    logic              block_close;
    logic              gain_needed;

    // Serial units
    logic              root_done;
    logic [SW-1:0]     root_val;
    logic              div_done;
    logic [DIVD_W-1:0] div_quo;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVR_W-1:0] div_divisor;

    // Sample-side combinational values
    logic [SW:0]       di, dq;
    logic [SW:0]       di_mag, dq_mag;
    logic [SW-1:0]     di_abs, dq_abs;
    logic [CNT_W-1:0]  count_inc;
    logic [NUM_W-1:0]  num;
    logic [SW-1:0]     audio_am;
    logic [SUM_W:0]    sum_add;
    logic [AVG_W-1:0]  avg;

    assign in_xfer     = in_valid && !in_stall_int;
    assign out_free    = !out_valid_reg || !out_stall;
    assign gain_needed = agc_en_reg && (peak_reg != '0);

    // Centering, magnitude of I/Q, saturating count
    always_comb
    begin
        di        = {1'b0, i_sample} - {1'b0, OFS};
        dq        = {1'b0, q_sample} - {1'b0, OFS};
        di_mag    = di[SW] ? (~di + 1'b1) : di;
        dq_mag    = dq[SW] ? (~dq + 1'b1) : dq;
        di_abs    = di_mag[SW-1:0];
        dq_abs    = dq_mag[SW-1:0];
        count_inc = (count_reg != '1) ? count_reg + 1'b1 : count_reg;
    end

    // AM audio: OFS + m minus the interpolated half DC level, clamped
    always_comb
    begin
        num = ((NUM_W'(OFS) + NUM_W'(root_val)) << (LEN_LOG2 + 1)) - x_reg;
        if (num[NUM_W-1])
            audio_am = '0;
        else if (num[NUM_W-2:SW+LEN_LOG2+1] != '0)
            audio_am = FULL_MAX;
        else
            audio_am = num[SW+LEN_LOG2:LEN_LOG2+1];
        sum_add = {1'b0, sum_reg} + (SUM_W+1)'(root_val);
        avg     = div_quo[AVG_W-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = (mode_reg == MODE_AM) ? ST_MUL : ST_RESULT;
            end
            ST_MUL:
            begin
                if (step_reg == STEP_W'(MUL_STEPS))
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done)
                    state_next = ST_AUDIO;
            end
            ST_AUDIO:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                    state_next = last_reg ? ST_AVG : ST_IDLE;
            end
            ST_AVG:
            begin
                if (div_done)
                    state_next = gain_needed ? ST_GAIN : ST_IDLE;
            end
            ST_GAIN:
            begin
                if (div_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_stall_int = 1'b1;
        mul_step     = 1'b0;
        root_start   = 1'b0;
        out_load     = 1'b0;
        div_start    = 1'b0;
        block_close  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall_int = 1'b0;
            end
            ST_MUL:
            begin
                mul_step   = (step_reg != STEP_W'(MUL_STEPS));
                root_start = (step_reg == STEP_W'(MUL_STEPS));
            end
            ST_RESULT:
            begin
                out_load  = out_free;
                div_start = out_free && last_reg;
            end
            ST_AVG:
            begin
                div_start   = div_done && gain_needed;
                block_close = div_done && !gain_needed;
            end
            ST_GAIN:
            begin
                block_close = div_done;
            end
            default:
            begin
                in_stall_int = 1'b1;
            end
        endcase
    end

    // Divider operands: block average first, then the gain reciprocal
    always_comb
    begin
        if (state_reg == ST_AVG)
        begin
            div_dividend = GAIN_NUM;
            div_divisor  = DIVR_W'(peak_reg);
        end
        else
        begin
            div_dividend = DIVD_W'(sum_reg);
            div_divisor  = DIVR_W'(count_reg);
        end
    end

    // Control state, configuration and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_AM;
            agc_en_reg    <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            prev_reg      <= '0;
            slope_reg     <= '0;
            peak_reg      <= '0;
            gain_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Register writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DEMOD_MODE: mode_reg   <= demod_mode_t'(cfg_data[1:0]);
                    REG_AGC_ENABLE: agc_en_reg <= cfg_data[0];
                    default:        mode_reg   <= mode_reg;
                endcase
            end

            // Per-sample count and peak
            if (in_xfer)
            begin
                count_reg <= count_inc;
                if (agc_en_reg && (di_abs > peak_reg))
                    peak_reg <= di_abs;
            end

            // Magnitude sum, AM only, saturating
            if (state_reg == ST_AUDIO)
                sum_reg <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

            // Output register
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            // Block end: average and slope, then gain
            if ((state_reg == ST_AVG) && div_done)
            begin
                prev_reg  <= avg;
                slope_reg <= SLP_W'(avg) - SLP_W'(prev_reg);
                if (agc_en_reg && (peak_reg == '0))
                    gain_reg <= GAIN_MAX;
            end
            if ((state_reg == ST_GAIN) && div_done)
            begin
                gain_reg <= (div_quo > DIVD_W'(GAIN_MAX)) ? GAIN_MAX : div_quo[GAIN_W-1:0];
            end
            if (block_close)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                peak_reg  <= '0;
            end
        end
    end

    // Step counter for the multipliers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (in_xfer)
            step_reg <= '0;
        else if (mul_step)
            step_reg <= step_reg + 1'b1;
    end

    // Item datapath
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mcand_i_reg    <= (2*SW)'(di_abs);
            mcand_q_reg    <= (2*SW)'(dq_abs);
            mpl_i_reg      <= di_abs;
            mpl_q_reg      <= dq_abs;
            sq_i_reg       <= '0;
            sq_q_reg       <= '0;
            prod_mcand_reg <= {{(PROD_W-SLP_W){slope_reg[SLP_W-1]}}, slope_reg};
            prod_mpl_reg   <= count_inc;
            prod_reg       <= '0;
            audio_calc_reg <= i_sample;
            last_reg       <= block_last;
        end
        else if (mul_step)
        begin
            // I^2, Q^2 and slope*k, one multiplier bit per cycle
            if (mpl_i_reg[0])
                sq_i_reg <= sq_i_reg + mcand_i_reg;
            if (mpl_q_reg[0])
                sq_q_reg <= sq_q_reg + mcand_q_reg;
            if (prod_mpl_reg[0])
                prod_reg <= prod_reg + prod_mcand_reg;
            mcand_i_reg    <= mcand_i_reg << 1;
            mcand_q_reg    <= mcand_q_reg << 1;
            prod_mcand_reg <= prod_mcand_reg << 1;
            mpl_i_reg      <= mpl_i_reg >> 1;
            mpl_q_reg      <= mpl_q_reg >> 1;
            prod_mpl_reg   <= prod_mpl_reg >> 1;
        end

        // DC term: L*prev + slope*k
        if (state_reg == ST_ROOT)
            x_reg <= (NUM_W'(prev_reg) << LEN_LOG2)
                     + {{(NUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

        if (state_reg == ST_AUDIO)
            audio_calc_reg <= audio_am;

        if (out_load)
        begin
            audio_out_reg <= audio_calc_reg;
            gain_out_reg  <= gain_reg;
            narrow_reg    <= (mode_reg == MODE_CW);
            block_end_reg <= last_reg;
        end
    end

    iqd_sqrt_serial #(
        .RT_W (SW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sq_i_reg + sq_q_reg),
        .done     (root_done),
        .root     (root_val)
    );

    iqd_div_serial #(
        .DIVD_W (DIVD_W),
        .DIVR_W (DIVR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign in_stall              = in_stall_int;
    assign out_valid             = out_valid_reg;
    assign audio_sample          = audio_out_reg;
    assign agc_gain              = gain_out_reg;
    assign narrow_filter_request = narrow_reg;
    assign block_end             = block_end_reg;

endmodule

// File: src/iqd_chk.sv
module iqd_chk
    import iqd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [SAMPLE_WIDTH-1:0] audio_sample,
    input logic [GAIN_W-1:0]       agc_gain,
    input logic                    narrow_filter_request,
    input logic                    block_end
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(audio_sample)
            && $stable(agc_gain) && $stable(narrow_filter_request) && $stable(block_end))
        else $error("stalled result changed");

    // Reported gain never exceeds the ceiling
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> agc_gain <= GAIN_MAX)
        else $error("gain above ceiling");

    // One item at a time: busy right after an input transfer
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while busy");

    // A block's last result starts the block-end update, so input is held off
    a_block_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) && block_end |-> in_stall)
        else $error("input open during block-end update");

endmodule

bind iq_demodulator_dc_agc iqd_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_chk (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import iqd_pkg::*;
();

    localparam int     SW         = 16;
    localparam int     INTERP_LEN = 256;
    localparam longint OFS        = 32768;
    localparam longint SUM_CAP    = 64'h0000_0000_FFFF_FFFF;
    localparam int     IDLE_LIMIT = 4000;
    localparam int     SETTLE     = 150;
    localparam int     HOLD_LEN   = 400;
    localparam int     HOLD_AT    = 120;

    typedef struct packed {
        logic [SW-1:0] i_val;
        logic [SW-1:0] q_val;
        logic          last;
    } iq_pair_t;

    typedef struct packed {
        logic [SW-1:0]     audio;
        logic [GAIN_W-1:0] gain;
        logic              narrow;
        logic              bend;
    } audio_out_t;

    // DUT signals; the inputs are known from time zero
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [SW-1:0]          i_sample = '0;
    logic [SW-1:0]          q_sample = '0;
    logic                   block_last = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [SW-1:0]          audio_sample;
    logic [GAIN_W-1:0]      agc_gain;
    logic                   narrow_filter_request;
    logic                   block_end;

    // Stimulus and scoreboard
    iq_pair_t   pairs_to_send[$];
    audio_out_t expected_audio_q[$];
    logic       calm = 1'b0;
    int         send_wait;
    int         recv_wait;
    int         hold_left;
    logic       hold_done;
    int         idle_cycles;
    int         pairs_sent = 0;
    int         results_seen;
    int         mismatches = 0;

    // Predictor state and configuration copy
    demod_mode_t       mode_q;
    logic              agc_on_q;
    longint            blk_count;
    longint            mag_sum;
    longint            prev_avg;
    longint            slope;
    longint            peak_abs;
    logic [GAIN_W-1:0] gain_q;

    iq_demodulator_dc_agc dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .i_sample              (i_sample),
        .q_sample              (q_sample),
        .block_last            (block_last),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .audio_sample          (audio_sample),
        .agc_gain              (agc_gain),
        .narrow_filter_request (narrow_filter_request),
        .block_end             (block_end)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Floor square root, one result bit per pass
    function automatic longint int_root(input longint v);
        longint r;
        longint trial;
        r = 0;
        for (int s = 16; s >= 0; s--)
        begin
            trial = r | (longint'(1) << s);
            if (trial * trial <= v)
                r = trial;
        end
        return r;
    endfunction

    // Envelope/passthrough output for one pair, block-end updates included
    function automatic audio_out_t demodulate_pair(input iq_pair_t p);
        audio_out_t r;
        longint     di;
        longint     dq;
        longint     mag;
        longint     num;
        longint     lvl;
        longint     avg;
        longint     g;
        di = longint'(p.i_val) - OFS;
        dq = longint'(p.q_val) - OFS;
        r.audio = p.i_val;
        if (blk_count < 65535)
            blk_count++;
        if (agc_on_q)
        begin
            lvl = (di < 0) ? -di : di;
            if (lvl > peak_abs)
                peak_abs = lvl;
        end
        if (mode_q == MODE_AM)
        begin
            mag = int_root(di * di + dq * dq);
            mag_sum = mag_sum + mag;
            if (mag_sum > SUM_CAP)
                mag_sum = SUM_CAP;
            // DC level interpolated across the block, halved
            num = 2 * INTERP_LEN * (OFS + mag) - INTERP_LEN * prev_avg - slope * blk_count;
            if (num < 0)
                r.audio = '0;
            else if (num / (2 * INTERP_LEN) > 65535)
                r.audio = '1;
            else
            begin
                num = num / (2 * INTERP_LEN);
                r.audio = num[SW-1:0];
            end
        end
        r.gain   = gain_q;
        r.narrow = (mode_q == MODE_CW);
        r.bend   = p.last;
        if (p.last)
        begin
            avg = mag_sum / blk_count;
            slope = avg - prev_avg;
            prev_avg = avg;
            if (agc_on_q)
            begin
                g = GAIN_MAX;
                if (peak_abs != 0)
                begin
                    g = (OFS << GAIN_FRAC) / peak_abs;
                    if (g > GAIN_MAX)
                        g = GAIN_MAX;
                end
                gain_q = g[GAIN_W-1:0];
            end
            blk_count = 0;
            mag_sum = 0;
            peak_abs = 0;
        end
        return r;
    endfunction

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic void push_pair(input logic [SW-1:0] iv, input logic [SW-1:0] qv,
                                      input logic last);
        iq_pair_t p;
        p.i_val = iv;
        p.q_val = qv;
        p.last  = last;
        pairs_to_send.push_back(p);
    endfunction

    // Extremes, near-center values and full-range noise
    function automatic logic [SW-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 16'h8000;
            3: return 16'(32760 + $urandom_range(0, 16));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_DEMOD_MODE)
            mode_q = demod_mode_t'(val);
        else
            agc_on_q = val[0];
    endtask

    task automatic set_config(input demod_mode_t m, input logic agc);
        write_reg(REG_DEMOD_MODE, m);
        write_reg(REG_AGC_ENABLE, {1'b0, agc});
    endtask

    // Block until every pair is through, then let block-end divisions finish
    task automatic wait_idle();
        @(negedge clk);
        while (pairs_to_send.size() != 0 || in_valid || expected_audio_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Random blocks, mostly short, some long; optionally leave the last block open
    task automatic random_phase(input int n_pairs, input bit cut_block, input bit no_idle);
        int left;
        int blen;
        @(negedge clk);
        calm = no_idle;
        left = n_pairs;
        while (left > 0)
        begin
            blen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
            if (blen > left)
                blen = left;
            for (int k = 1; k <= blen; k++)
                push_pair(draw_sample(), draw_sample(),
                          k == blen && !(cut_block && left == blen));
            left -= blen;
        end
    endtask

    // Input driver: one pair per transfer, random gap after each unless calm is set
    always @(posedge clk or negedge rst_n)
    begin
        iq_pair_t nxt;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            i_sample   <= '0;
            q_sample   <= '0;
            block_last <= 1'b0;
            send_wait  <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                nxt.i_val = i_sample;
                nxt.q_val = q_sample;
                nxt.last  = block_last;
                expected_audio_q.push_back(demodulate_pair(nxt));
                pairs_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_wait != 0)
                begin
                    send_wait <= send_wait - 1;
                    in_valid  <= 1'b0;
                end
                else if (pairs_to_send.size() != 0)
                begin
                    nxt = pairs_to_send.pop_front();
                    i_sample   <= nxt.i_val;
                    q_sample   <= nxt.q_val;
                    block_last <= nxt.last;
                    in_valid   <= 1'b1;
                    send_wait  <= draw_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        audio_out_t got;
        audio_out_t want;
        int         wait_now;
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            recv_wait    <= 0;
            results_seen <= 0;
        end
        else
        begin
            wait_now = recv_wait;
            if (out_valid && !out_stall)
            begin
                got.audio  = audio_sample;
                got.gain   = agc_gain;
                got.narrow = narrow_filter_request;
                got.bend   = block_end;
                results_seen <= results_seen + 1;
                if (expected_audio_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: extra result audio=%0d gain=%0d nf=%0b end=%0b",
                                 $realtime, got.audio, got.gain, got.narrow, got.bend);
                end
                else
                begin
                    want = expected_audio_q.pop_front();
                    if (got.audio !== want.audio || got.gain !== want.gain ||
                        got.narrow !== want.narrow || got.bend !== want.bend)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result %0d exp audio=%0d gain=%0d nf=%0b end=%0b",
                                     $realtime, results_seen, want.audio, want.gain,
                                     want.narrow, want.bend);
                            $display("    got audio=%0d gain=%0d nf=%0b end=%0b",
                                     got.audio, got.gain, got.narrow, got.bend);
                        end
                    end
                end
                wait_now = draw_gap();
            end
            else if (wait_now != 0)
                wait_now--;
            recv_wait <= wait_now;
            out_stall <= (wait_now != 0) || (hold_left != 0);
        end
    end

    // One long receiver hold-off so the core and output register back up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles, %0d results pending",
                         idle_cycles, expected_audio_q.size());
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial
    begin
        mode_q    = MODE_AM;
        agc_on_q  = 1'b0;
        blk_count = 0;
        mag_sum   = 0;
        prev_avg  = 0;
        slope     = 0;
        peak_abs  = 0;
        gain_q    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes in AM with AGC on; saturated envelope, full-scale peak
        set_config(MODE_AM, 1'b1);
        @(negedge clk);
        push_pair(16'h0000, 16'h0000, 1'b0);
        push_pair(16'hFFFF, 16'hFFFF, 1'b0);
        push_pair(16'h8000, 16'h8000, 1'b0);
        push_pair(16'hFFFF, 16'h0000, 1'b0);
        push_pair(16'h0000, 16'h8000, 1'b1);
        wait_idle();

        // Zero peak: gain goes to the ceiling
        @(negedge clk);
        push_pair(16'h8000, 16'h8000, 1'b0);
        push_pair(16'h8000, 16'h0000, 1'b1);
        wait_idle();

        // Block started in AM and closed in LSB: partial average
        set_config(MODE_AM, 1'b0);
        @(negedge clk);
        push_pair(16'd40000, 16'd30000, 1'b0);
        push_pair(16'd12345, 16'd54321, 1'b0);
        wait_idle();
        set_config(MODE_LOWER, 1'b0);
        @(negedge clk);
        push_pair(16'd1, 16'd65534, 1'b0);
        push_pair(16'h8000, 16'h8000, 1'b1);
        wait_idle();

        // CW with AGC off: gain held, narrow filter asked
        set_config(MODE_CW, 1'b0);
        @(negedge clk);
        push_pair(16'hFFFF, 16'h0000, 1'b0);
        push_pair(16'h0000, 16'hFFFF, 1'b1);
        wait_idle();

        // Whole block in USB: zero average, AGC still tracks the peak
        set_config(MODE_UPPER, 1'b1);
        @(negedge clk);
        push_pair(16'd21845, 16'd43690, 1'b0);
        push_pair(16'd43690, 16'd21845, 1'b1);
        push_pair(16'd32767, 16'd32769, 1'b1);
        wait_idle();

        // Random phases across modes and AGC settings
        for (int p = 0; p < 8; p++)
        begin
            if (p < 4)
                set_config(demod_mode_t'(p), p[1]);
            else if ($urandom_range(0, 2) == 0)
                set_config(demod_mode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
            else
                set_config(MODE_AM, 1'($urandom_range(0, 1)));
            random_phase(62, p % 3 == 1, p == 2 || p == 5);
            wait_idle();
        end

        // DC ramp: flat block, loud block, then a long quiet block driven to zero
        set_config(MODE_AM, 1'b0);
        @(negedge clk);
        calm = 1'b0;
        push_pair(16'h8000, 16'h8000, 1'b1);
        push_pair(16'h0000, 16'h0000, 1'b0);
        push_pair(16'h0000, 16'h0000, 1'b1);
        for (int k = 1; k <= 130; k++)
            push_pair(16'(32768 + $urandom_range(0, 3)), 16'h8000, k == 130);
        wait_idle();

        // AM with AGC on after the ramp: mixed levels in one short block
        set_config(MODE_AM, 1'b1);
        @(negedge clk);
        calm = 1'b0;
        push_pair(16'd30000, 16'd36000, 1'b0);
        push_pair(16'hFFFF, 16'h8000, 1'b0);
        push_pair(16'h0123, 16'hFEDC, 1'b1);
        wait_idle();

        mismatches += expected_audio_q.size();
        $display("run covered AM, USB, LSB and CW with AGC on and off, long receiver stalls");
        $display("and a DC ramp to zero: %0d pairs sent, %0d results checked, %0d mismatches",
                 pairs_sent, results_seen, mismatches);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
